FILE: design/vcsp_pkg.sv
// Shared types and constants for the vector-unit interface command stream parser.
`default_nettype none
package vcsp_pkg;

  localparam int unsigned CODE_BYTES   = 16384;
  localparam int unsigned DATA_BYTES   = 16384;
  localparam int unsigned BUFFER_WORDS = 1048576;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEFT_W  = 21;
  localparam int unsigned REST_W  = 20;
  localparam int unsigned TOGO_W  = 19;
  localparam int unsigned DEST_W  = 16;
  localparam int unsigned ADDR_W  = 14;
  localparam int unsigned PC_W    = 19;
  localparam int unsigned TOP_W   = 10;
  localparam int unsigned ACT_W   = 3;

  // Actions reported on the result channel
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CODE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DATA   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FWD    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd4;

  // Opcodes
  localparam logic [6:0] OP_CYCLE  = 7'h01;
  localparam logic [6:0] OP_OFFSET = 7'h02;
  localparam logic [6:0] OP_BASE   = 7'h03;
  localparam logic [6:0] OP_TOP    = 7'h04;
  localparam logic [6:0] OP_MODE   = 7'h05;
  localparam logic [6:0] OP_MASKP3 = 7'h06;
  localparam logic [6:0] OP_MSCAL  = 7'h14;
  localparam logic [6:0] OP_MSCALF = 7'h15;
  localparam logic [6:0] OP_MASK   = 7'h20;
  localparam logic [6:0] OP_ROW    = 7'h30;
  localparam logic [6:0] OP_COL    = 7'h31;
  localparam logic [6:0] OP_MPG    = 7'h4A;
  localparam logic [6:0] OP_DIRECT = 7'h50;
  localparam logic [6:0] OP_DIRHL  = 7'h51;

  typedef enum logic [6:0] {
    PH_CMD     = 7'b0000001,
    PH_SKIP    = 7'b0000010,
    PH_CODE    = 7'b0000100,
    PH_LINEAR  = 7'b0001000,
    PH_WRAP    = 7'b0010000,
    PH_DIRECT  = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [TOGO_W-1:0]   words_to_go;
    logic [DEST_W-1:0]   dest_address;
    logic                payload_writes;
    logic [15:0]         cycle_reg;
    logic [TOP_W-1:0]    offset_reg;
    logic [TOP_W-1:0]    base_reg;
    logic [TOP_W-1:0]    top_reg;
    logic [1:0]          mode_reg;
    logic                path3_mask;
  } parse_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] write_address;
    logic [WORD_W-1:0] data_word;
    logic [PC_W-1:0]   start_pc;
    logic [TOP_W-1:0]  start_top;
    logic              path3_masked;
  } result_t;

endpackage
`default_nettype wire

FILE: design/vcsp_decode.sv
// Single-pass decode of one stream word against the parser state.
`default_nettype none
module vcsp_decode (
  input  wire logic [vcsp_pkg::WORD_W-1:0] word,
  input  wire logic [vcsp_pkg::LEFT_W-1:0] words_left,
  input  wire vcsp_pkg::parse_state_t      st,
  output vcsp_pkg::parse_state_t           st_nxt,
  output vcsp_pkg::result_t                res
);

  localparam logic [vcsp_pkg::DEST_W-1:0] DEST_LIM_CODE = vcsp_pkg::DEST_W'(vcsp_pkg::CODE_BYTES);
  localparam logic [vcsp_pkg::DEST_W-1:0] DEST_LIM_DATA = vcsp_pkg::DEST_W'(vcsp_pkg::DATA_BYTES);

  always_comb begin
    logic [vcsp_pkg::LEFT_W-1:0] wl;
    logic [vcsp_pkg::REST_W-1:0] rest;
    logic [6:0]  op;
    logic [7:0]  num;
    logic [15:0] imm;
    logic [18:0] dst;
    logic [11:0] bytes;
    logic [19:0] copy;
    logic [16:0] q;
    logic [17:0] avail;
    logic        trunc;
    logic [4:0]  bpv;
    logic [12:0] prod;
    logic [12:0] total;
    logic [1:0]  vn;
    logic [1:0]  vl;
    logic [9:0]  va;
    logic [vcsp_pkg::TOGO_W-1:0] togo;

    st_nxt = st;
    res    = '0;
    copy   = '0;
    bpv    = '0;
    togo   = '0;

    // Clamp the buffer count
    if (words_left == '0) begin
      wl = vcsp_pkg::LEFT_W'(1);
    end else if (words_left > vcsp_pkg::LEFT_W'(vcsp_pkg::BUFFER_WORDS)) begin
      wl = vcsp_pkg::LEFT_W'(vcsp_pkg::BUFFER_WORDS);
    end else begin
      wl = words_left;
    end
    rest = vcsp_pkg::REST_W'(wl - vcsp_pkg::LEFT_W'(1));

    op  = word[30:24];
    num = word[23:16];
    imm = word[15:0];
    dst   = {imm, 3'b000};
    bytes = ({1'b0, num, 3'b000} + 12'd15) & 12'hFF0;
    q     = (imm == 16'd0) ? 17'h10000 : {1'b0, imm};
    avail = rest[19:2];
    trunc = {1'b0, q} > avail;
    vn = op[3:2];
    vl = op[1:0];
    va = imm[9:0];

    // Bytes per vector for unpack
    case (vl)
      2'd0:    bpv = {1'b0, vn, 2'b00} + 5'd4;
      2'd1:    bpv = {2'b00, vn, 1'b0} + 5'd2;
      2'd2:    bpv = {3'b000, vn} + 5'd1;
      default: bpv = (vn == 2'd3) ? 5'd2 : ({2'b00, vn, 1'b0} + 5'd2);
    endcase
    prod  = 13'(num * bpv);
    total = (prod + 13'd3) & 13'h1FFC;

    res.path3_masked = st.path3_mask;

    case (st.phase)
      // Command word
      vcsp_pkg::PH_CMD: begin
        st_nxt.payload_writes = 1'b0;
        if (op == vcsp_pkg::OP_CYCLE) begin
          st_nxt.cycle_reg = imm;
        end else if (op == vcsp_pkg::OP_OFFSET) begin
          st_nxt.offset_reg = imm[9:0];
        end else if (op == vcsp_pkg::OP_BASE) begin
          st_nxt.base_reg = imm[9:0];
        end else if (op == vcsp_pkg::OP_TOP) begin
          st_nxt.top_reg = imm[9:0];
        end else if (op == vcsp_pkg::OP_MODE) begin
          st_nxt.mode_reg = imm[1:0];
        end else if (op == vcsp_pkg::OP_MASKP3) begin
          st_nxt.path3_mask = imm[0];
        end else if (op == vcsp_pkg::OP_MSCAL || op == vcsp_pkg::OP_MSCALF) begin
          res.action    = vcsp_pkg::ACT_START;
          res.start_pc  = dst;
          res.start_top = st.top_reg;
        end else if (op == vcsp_pkg::OP_MASK) begin
          st_nxt.phase       = vcsp_pkg::PH_SKIP;
          st_nxt.words_to_go = vcsp_pkg::TOGO_W'(1);
        end else if (op == vcsp_pkg::OP_ROW || op == vcsp_pkg::OP_COL) begin
          st_nxt.phase       = vcsp_pkg::PH_SKIP;
          st_nxt.words_to_go = vcsp_pkg::TOGO_W'(4);
        end else if (op == vcsp_pkg::OP_MPG) begin
          if (dst < 19'(vcsp_pkg::CODE_BYTES) && bytes != 12'd0) begin
            if ((20'(dst) + 20'(bytes)) > 20'(vcsp_pkg::CODE_BYTES)) begin
              copy = 20'(vcsp_pkg::CODE_BYTES) - 20'(dst);
            end else begin
              copy = 20'(bytes);
            end
            st_nxt.payload_writes = copy[19:2] <= rest[17:0] && rest[19:18] == 2'd0
                                    || rest[19:18] != 2'd0;
          end
          st_nxt.dest_address = dst[vcsp_pkg::DEST_W-1:0];
          if (bytes != 12'd0) begin
            st_nxt.phase       = vcsp_pkg::PH_CODE;
            st_nxt.words_to_go = vcsp_pkg::TOGO_W'(bytes[11:2]);
          end
        end else if (op == vcsp_pkg::OP_DIRECT || op == vcsp_pkg::OP_DIRHL) begin
          st_nxt.payload_writes = trunc;
          togo = trunc ? {avail[16:0], 2'b00} : {q, 2'b00};
          if (togo != '0) begin
            st_nxt.phase       = vcsp_pkg::PH_DIRECT;
            st_nxt.words_to_go = togo;
          end else begin
            st_nxt.phase = vcsp_pkg::PH_DISCARD;
          end
        end else if (op[6:5] == 2'b11) begin
          st_nxt.payload_writes = total != 13'd0 && 20'(total[12:2]) <= rest &&
                                  17'({va, 4'b0000}) < 17'(vcsp_pkg::DATA_BYTES);
          st_nxt.dest_address   = {2'b00, va, 4'b0000};
          if (total != 13'd0) begin
            st_nxt.phase       = (bpv == 5'd16) ? vcsp_pkg::PH_WRAP : vcsp_pkg::PH_LINEAR;
            st_nxt.words_to_go = vcsp_pkg::TOGO_W'(total[12:2]);
          end
        end
      end
      vcsp_pkg::PH_DISCARD: begin
      end
      // Payload word
      default: begin
        case (st.phase)
          vcsp_pkg::PH_CODE: begin
            if (st.payload_writes && st.dest_address < DEST_LIM_CODE) begin
              res.action        = vcsp_pkg::ACT_CODE;
              res.write_address = st.dest_address[vcsp_pkg::ADDR_W-1:0];
              res.data_word     = word;
            end
            st_nxt.dest_address = st.dest_address + vcsp_pkg::DEST_W'(4);
          end
          vcsp_pkg::PH_LINEAR: begin
            if (st.payload_writes && st.dest_address < DEST_LIM_DATA) begin
              res.action        = vcsp_pkg::ACT_DATA;
              res.write_address = st.dest_address[vcsp_pkg::ADDR_W-1:0];
              res.data_word     = word;
            end
            st_nxt.dest_address = st.dest_address + vcsp_pkg::DEST_W'(4);
          end
          vcsp_pkg::PH_WRAP: begin
            if (st.payload_writes &&
                ({1'b0, st.dest_address & 16'hFFF0} + 17'd16) <= 17'(vcsp_pkg::DATA_BYTES)) begin
              res.action        = vcsp_pkg::ACT_DATA;
              res.write_address = st.dest_address[vcsp_pkg::ADDR_W-1:0];
              res.data_word     = word;
            end
            st_nxt.dest_address = (st.dest_address + vcsp_pkg::DEST_W'(4)) & 16'h3FFF;
          end
          vcsp_pkg::PH_DIRECT: begin
            res.action    = vcsp_pkg::ACT_FWD;
            res.data_word = word;
          end
          default: begin
          end
        endcase
        togo = (st.words_to_go != '0) ? st.words_to_go - vcsp_pkg::TOGO_W'(1)
                                      : st.words_to_go;
        st_nxt.words_to_go = togo;
        if (togo == '0) begin
          st_nxt.phase = (st.phase == vcsp_pkg::PH_DIRECT && st.payload_writes)
                         ? vcsp_pkg::PH_DISCARD : vcsp_pkg::PH_CMD;
        end
      end
    endcase

    res.path3_masked = st_nxt.path3_mask;

    // Buffer end restarts parsing
    if (wl == vcsp_pkg::LEFT_W'(1)) begin
      st_nxt.phase       = vcsp_pkg::PH_CMD;
      st_nxt.words_to_go = '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/vif_command_stream_parser.sv
// Top level of the vector-unit interface command stream parser.
// Each accepted word yields exactly one result word. A word passes through an
// input register, one decode step against the parser state, and a result
// register; a new word is taken every cycle while the result side keeps up,
// so throughput is one word per cycle. The input register is held when the
// result register is full and stalled.
`default_nettype none
module vif_command_stream_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [vcsp_pkg::WORD_W-1:0]    in_stream_word,
  input  wire logic [vcsp_pkg::LEFT_W-1:0]    in_words_left,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [vcsp_pkg::ACT_W-1:0]          out_action,
  output logic [vcsp_pkg::ADDR_W-1:0]         out_write_address,
  output logic [vcsp_pkg::WORD_W-1:0]         out_data_word,
  output logic [vcsp_pkg::PC_W-1:0]           out_start_pc,
  output logic [vcsp_pkg::TOP_W-1:0]          out_start_top,
  output logic                                out_path3_masked
);

  logic                          in_valid_r;
  logic [vcsp_pkg::WORD_W-1:0]   in_word_r;
  logic [vcsp_pkg::LEFT_W-1:0]   in_left_r;
  logic                          out_valid_r;
  vcsp_pkg::result_t             res_r;
  vcsp_pkg::result_t             res_nxt;
  vcsp_pkg::parse_state_t        st_r;
  vcsp_pkg::parse_state_t        st_nxt;
  logic                          advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  vcsp_decode u_decode (
    .word       (in_word_r),
    .words_left (in_left_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_word_r <= in_stream_word;
      in_left_r <= in_words_left;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      st_r        <= '{phase: vcsp_pkg::PH_CMD, default: '0};
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = res_r.action;
  assign out_write_address = res_r.write_address;
  assign out_data_word     = res_r.data_word;
  assign out_start_pc      = res_r.start_pc;
  assign out_start_top     = res_r.start_top;
  assign out_path3_masked  = res_r.path3_masked;

endmodule
`default_nettype wire

FILE: tb/vif_command_stream_parser_tb.sv
// Self-checking testbench for the vector-unit interface command stream parser.
`default_nettype none
module vif_command_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // Internal parser phases of the predictor
  typedef enum int unsigned {
    P_CMD, P_SKIP, P_CODE, P_LINEAR, P_WRAP, P_DIRECT, P_DISCARD
  } pphase_t;

  typedef struct {
    logic [31:0]       word;
    logic [20:0]       left;
    bit                has_exp;
    vcsp_pkg::result_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [vcsp_pkg::WORD_W-1:0] in_stream_word = '0;
  logic [vcsp_pkg::LEFT_W-1:0] in_words_left = 21'd1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [vcsp_pkg::ACT_W-1:0] out_action;
  logic [vcsp_pkg::ADDR_W-1:0] out_write_address;
  logic [vcsp_pkg::WORD_W-1:0] out_data_word;
  logic [vcsp_pkg::PC_W-1:0] out_start_pc;
  logic [vcsp_pkg::TOP_W-1:0] out_start_top;
  logic out_path3_masked;

  vif_command_stream_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stream_word(in_stream_word), .in_words_left(in_words_left),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_action(out_action), .out_write_address(out_write_address),
    .out_data_word(out_data_word), .out_start_pc(out_start_pc),
    .out_start_top(out_start_top), .out_path3_masked(out_path3_masked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  pphase_t     pr_phase;
  int unsigned pr_togo;
  int unsigned pr_dest;
  bit          pr_writes;
  logic [15:0] pr_cycle;
  logic [9:0]  pr_offset, pr_base, pr_top;
  logic [1:0]  pr_mode;
  bit          pr_mask;

  vcsp_pkg::result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned words_checked = 0;
  int unsigned cycles = 0;
  int unsigned act_seen[5];
  int unsigned out_wait = 0;

  function automatic void predictor_reset();
    pr_phase = P_CMD; pr_togo = 0; pr_dest = 0; pr_writes = 0;
    pr_cycle = '0; pr_offset = '0; pr_base = '0; pr_top = '0;
    pr_mode = '0; pr_mask = 0;
  endfunction

  function automatic void begin_payload(pphase_t ph, int unsigned n);
    if (n > 0) begin
      pr_phase = ph;
      pr_togo = n;
    end
  endfunction

  // Decode one command word; returns the result fields it causes
  function automatic void decode_cmd(logic [31:0] w, int unsigned rest,
                                     ref vcsp_pkg::result_t r);
    logic [6:0] op;
    int unsigned num, imm, dst, bytes, copy, q, avail, vn, vl, bpv, total, va;
    bit trunc;
    op = w[30:24];
    num = w[23:16];
    imm = w[15:0];
    pr_writes = 0;
    case (op)
      vcsp_pkg::OP_CYCLE:  pr_cycle = imm[15:0];
      vcsp_pkg::OP_OFFSET: pr_offset = imm[9:0];
      vcsp_pkg::OP_BASE:   pr_base = imm[9:0];
      vcsp_pkg::OP_TOP:    pr_top = imm[9:0];
      vcsp_pkg::OP_MODE:   pr_mode = imm[1:0];
      vcsp_pkg::OP_MASKP3: pr_mask = imm[0];
      vcsp_pkg::OP_MSCAL, vcsp_pkg::OP_MSCALF: begin
        r.action = vcsp_pkg::ACT_START;
        r.start_pc = vcsp_pkg::PC_W'(imm * 8);
        r.start_top = pr_top;
      end
      vcsp_pkg::OP_MASK: begin_payload(P_SKIP, 1);
      vcsp_pkg::OP_ROW, vcsp_pkg::OP_COL: begin_payload(P_SKIP, 4);
      vcsp_pkg::OP_MPG: begin
        dst = imm * 8;
        bytes = (num * 8 + 15) & ~32'd15;
        if (dst < vcsp_pkg::CODE_BYTES && bytes > 0) begin
          copy = bytes;
          if (dst + copy > vcsp_pkg::CODE_BYTES) copy = vcsp_pkg::CODE_BYTES - dst;
          pr_writes = (copy / 4) <= rest;
        end
        pr_dest = dst;
        begin_payload(P_CODE, bytes / 4);
      end
      vcsp_pkg::OP_DIRECT, vcsp_pkg::OP_DIRHL: begin
        q = (imm == 0) ? 65536 : imm;
        avail = rest / 4;
        trunc = q > avail;
        if (trunc) q = avail;
        pr_writes = trunc;
        if (q > 0) begin_payload(P_DIRECT, q * 4);
        else pr_phase = P_DISCARD;
      end
      default: begin
        if (op[6:5] == 2'b11) begin
          vn = op[3:2];
          vl = op[1:0];
          va = imm & 32'h3FF;
          if (vl == 0) bpv = 4 * (vn + 1);
          else if (vl == 1) bpv = 2 * (vn + 1);
          else if (vl == 2) bpv = vn + 1;
          else bpv = (vn == 3) ? 2 : 2 * (vn + 1);
          total = (num * bpv + 3) & ~32'd3;
          pr_writes = total > 0 && (total / 4) <= rest && va * 16 < vcsp_pkg::DATA_BYTES;
          pr_dest = va * 16;
          begin_payload(bpv == 16 ? P_WRAP : P_LINEAR, total / 4);
        end
      end
    endcase
  endfunction

  // Compute the result of one stream word and advance the predictor
  function automatic vcsp_pkg::result_t parse_word(logic [31:0] w, logic [20:0] left_in);
    vcsp_pkg::result_t r;
    int unsigned wl;
    pphase_t ph;
    r = '0;
    wl = left_in;
    if (wl == 0) wl = 1;
    if (wl > vcsp_pkg::BUFFER_WORDS) wl = vcsp_pkg::BUFFER_WORDS;
    ph = pr_phase;
    if (ph == P_CMD) begin
      decode_cmd(w, wl - 1, r);
    end else if (ph != P_DISCARD) begin
      case (ph)
        P_CODE: begin
          if (pr_writes && pr_dest < vcsp_pkg::CODE_BYTES) begin
            r.action = vcsp_pkg::ACT_CODE; r.write_address = pr_dest[13:0]; r.data_word = w;
          end
          pr_dest += 4;
        end
        P_LINEAR: begin
          if (pr_writes && pr_dest < vcsp_pkg::DATA_BYTES) begin
            r.action = vcsp_pkg::ACT_DATA; r.write_address = pr_dest[13:0]; r.data_word = w;
          end
          pr_dest += 4;
        end
        P_WRAP: begin
          if (pr_writes && (pr_dest & ~32'd15) + 16 <= vcsp_pkg::DATA_BYTES) begin
            r.action = vcsp_pkg::ACT_DATA; r.write_address = pr_dest[13:0]; r.data_word = w;
          end
          pr_dest = (pr_dest + 4) & 32'h3FFF;
        end
        P_DIRECT: begin
          r.action = vcsp_pkg::ACT_FWD; r.data_word = w;
        end
        default: ;
      endcase
      if (pr_togo > 0) pr_togo--;
      if (pr_togo == 0) pr_phase = (ph == P_DIRECT && pr_writes) ? P_DISCARD : P_CMD;
    end
    if (wl == 1) begin
      pr_phase = P_CMD;
      pr_togo = 0;
    end
    r.path3_masked = pr_mask;
    return r;
  endfunction

  function automatic logic [31:0] cmd(logic [6:0] op, logic [7:0] num, logic [15:0] imm);
    return {$urandom_range(0, 1) == 1, op, num, imm};
  endfunction

  // Send one word with a random pre-gap, then record its expectation
  task automatic send_word(logic [31:0] w, logic [20:0] left, bit has_exp,
                           vcsp_pkg::result_t exp_r);
    int unsigned gap;
    vcsp_pkg::result_t r;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_word <= w;
    in_words_left <= left;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = parse_word(w, left);
    if (has_exp && r !== exp_r) begin
      $display("%0t predictor disagrees with table: exp %h got %h", $time, exp_r, r);
      errors++;
    end
    expected_results.push_back(r);
  endtask

  // Receiver draws a wait for every result word it takes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else if (out_valid && !out_stall) begin
      out_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      out_stall <= (out_wait != 0);
    end else if (out_wait != 0) begin
      out_wait--;
      out_stall <= (out_wait != 0);
    end
  end

  // Result checker
  always @(posedge clk) begin
    vcsp_pkg::result_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result word action %0d", $time, out_action);
        errors++;
      end else begin
        e = expected_results.pop_front();
        words_checked++;
        if (e.action <= 4) act_seen[e.action]++;
        if (out_action !== e.action || out_write_address !== e.write_address ||
            out_data_word !== e.data_word || out_start_pc !== e.start_pc ||
            out_start_top !== e.start_top || out_path3_masked !== e.path3_masked) begin
          $display("%0t mismatch exp %h got %h", $time, e,
                   {out_action, out_write_address, out_data_word, out_start_pc,
                    out_start_top, out_path3_masked});
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One random command sequence, mostly well formed
  task automatic random_sequence(ref int unsigned sent, ref int unsigned buf_left);
    logic [6:0] op;
    logic [7:0] num;
    logic [15:0] imm;
    int unsigned pick, n;
    vcsp_pkg::result_t z;
    z = '0;
    if (buf_left == 0) buf_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                              : $urandom_range(10, 60);
    pick = $urandom_range(0, 11);
    num = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6));
    imm = 16'($urandom);
    case (pick)
      0: op = 7'($urandom_range(1, 6));
      1: op = $urandom_range(0, 1) ? vcsp_pkg::OP_MSCAL : vcsp_pkg::OP_MSCALF;
      2: op = vcsp_pkg::OP_MASK;
      3: op = $urandom_range(0, 1) ? vcsp_pkg::OP_ROW : vcsp_pkg::OP_COL;
      4, 5: begin
        op = vcsp_pkg::OP_MPG;
        if ($urandom_range(0, 2) != 0) imm = 16'($urandom_range(0, 2100));
      end
      6: begin
        op = $urandom_range(0, 1) ? vcsp_pkg::OP_DIRECT : vcsp_pkg::OP_DIRHL;
        if ($urandom_range(0, 7) != 0) imm = 16'($urandom_range(0, 5));
      end
      7, 8, 9: begin
        op = 7'($urandom_range(7'h60, 7'h7F));
        if ($urandom_range(0, 2) != 0) imm[9:0] = 10'($urandom_range(1015, 1023));
      end
      default: op = 7'($urandom);
    endcase
    n = 1 + ((op == vcsp_pkg::OP_MPG) ? num * 2 + 1 : (op[6:5] == 2'b11) ? num * 4 + 1 :
             (op == vcsp_pkg::OP_DIRECT || op == vcsp_pkg::OP_DIRHL) ? imm * 4 : 4);
    if (n > 40) n = 40;
    for (int i = 0; i < n && sent < 1525; i++) begin
      logic [20:0] left;
      left = 21'(buf_left);
      if ($urandom_range(0, 200) == 0) left = $urandom_range(0, 1) ? 21'd0 : 21'h1FFFFF;
      send_word(i == 0 ? cmd(op, num, imm) : 32'($urandom), left, 0, z);
      sent++;
      buf_left = (left <= 1) ? 0 : buf_left - 1;
    end
  endtask

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    vcsp_pkg::result_t x;
    int unsigned sent;
    int unsigned buf_left;
    int unsigned settle;
    predictor_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: word, words left, typed expectation where obvious
    x = '0;
    row = '{32'h0000_0000, 21'd1, 1, x}; rows.push_back(row);
    row = '{32'h8600_0001, 21'd5, 1, '{3'd0, 14'd0, 32'd0, 19'd0, 10'd0, 1'b1}};
    rows.push_back(row);
    row = '{32'h0400_FFFF, 21'd4, 0, x}; rows.push_back(row);
    row = '{32'h1400_FFFF, 21'd3, 1,
            '{vcsp_pkg::ACT_START, 14'd0, 32'd0, 19'h7FFF8, 10'h3FF, 1'b1}};
    rows.push_back(row);
    row = '{32'h0600_0000, 21'd2, 0, x}; rows.push_back(row);
    row = '{32'h0100_FFFF, 21'd1, 0, x}; rows.push_back(row);
    row = '{32'h4A01_07FE, 21'd8, 0, x}; rows.push_back(row);
    row = '{32'hFFFF_FFFF, 21'd7, 0, x}; rows.push_back(row);
    row = '{32'h1234_5678, 21'd6, 0, x}; rows.push_back(row);
    row = '{32'hDEAD_BEEF, 21'd5, 0, x}; rows.push_back(row);
    row = '{32'h0000_0000, 21'd4, 0, x}; rows.push_back(row);
    row = '{32'h6C02_03FF, 21'd9, 0, x}; rows.push_back(row);
    for (int i = 0; i < 8; i++) begin
      row = '{32'($urandom), 21'(8 - i), 0, x}; rows.push_back(row);
    end
    row = '{32'h5000_0002, 21'd5, 0, x}; rows.push_back(row);
    row = '{32'hAAAA_5555, 21'd4, 1,
            '{vcsp_pkg::ACT_FWD, 14'd0, 32'hAAAA_5555, 19'd0, 10'd0, 1'b0}};
    rows.push_back(row);
    row = '{32'h5555_AAAA, 21'd3, 0, x}; rows.push_back(row);
    row = '{32'h7F00_0000, 21'd0, 0, x}; rows.push_back(row);
    row = '{32'h0000_0000, 21'h1FFFFF, 0, x}; rows.push_back(row);
    foreach (rows[i]) send_word(rows[i].word, rows[i].left, rows[i].has_exp, rows[i].exp);

    // Random command sequences
    sent = rows.size();
    buf_left = 0;
    while (sent < 1525) random_sequence(sent, buf_left);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end
    $display("checked %0d result words: none %0d code %0d data %0d fwd %0d start %0d",
             words_checked, act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: vif_command_stream_parser.f
design/vcsp_pkg.sv
design/vcsp_decode.sv
design/vif_command_stream_parser.sv
tb/vif_command_stream_parser_tb.sv
